@@ rtl/h264dp_pkg.sv @@
// Shared types and helpers for the H.264 RTP depacketizer.
package h264dp_pkg;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ONE,
    KIND_PREFIX,
    KIND_PREFIX_BYTE,
    KIND_LONG
  } kind_e;

  // One queued command: what a single accepted input word expands into.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } cmd_t;

  localparam logic [7:0] StartCode0 = 8'h00;
  localparam logic [7:0] StartCode1 = 8'h00;
  localparam logic [7:0] StartCode2 = 8'h01;
  localparam logic [7:0] TopMask    = 8'he0;
  localparam logic [7:0] TypeMask   = 8'h1f;

  function automatic logic [1:0] last_index(input kind_e kind);
    logic [1:0] r;
    case (kind)
      KIND_PREFIX:      r = 2'd2;
      KIND_PREFIX_BYTE: r = 2'd3;
      KIND_LONG:        r = 2'd3;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] word_byte(input kind_e kind, input logic [1:0] idx,
                                           input logic [7:0] data);
    logic [7:0] r;
    case (kind)
      KIND_PREFIX, KIND_PREFIX_BYTE: begin
        case (idx)
          2'd0:    r = StartCode0;
          2'd1:    r = StartCode1;
          2'd2:    r = StartCode2;
          default: r = data;
        endcase
      end
      KIND_LONG: begin
        r = (idx == 2'd3) ? StartCode2 : StartCode0;
      end
      default: r = data;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/h264dp_front.sv @@
// Front end: tracks packet state and classifies each input word into a command.
module h264dp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               first_byte_i,
  input  logic               last_byte_i,
  output h264dp_pkg::cmd_t   cmd_o
);
  import h264dp_pkg::*;

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_ZEROS = 3'd1;
  localparam logic [2:0] MODE_PASS  = 3'd2;
  localparam logic [2:0] MODE_STAP  = 3'd3;
  localparam logic [2:0] MODE_FU    = 3'd4;
  localparam logic [2:0] MODE_DROP  = 3'd5;

  localparam logic [1:0] PHASE_SIZE_HI = 2'd0;
  localparam logic [1:0] PHASE_SIZE_LO = 2'd1;
  localparam logic [1:0] PHASE_DATA    = 2'd2;

  logic [2:0]  mode_q, mode_d;
  logic [1:0]  zeros_q, zeros_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  size_hi_q, size_hi_d;
  logic [15:0] remain_q, remain_d;
  logic [2:0]  top_q, top_d;
  // Set while the next word is the second of the packet: the FU-A header in FU-A mode.
  logic        fu_hdr_q, fu_hdr_d;

  logic [4:0]  type_field;
  logic [15:0] size_full;
  logic [15:0] remain_dec;

  assign type_field = in_byte_i[4:0];
  assign size_full  = {size_hi_q, in_byte_i};
  assign remain_dec = remain_q - 16'd1;

  always_comb begin
    mode_d     = mode_q;
    zeros_d    = zeros_q;
    phase_d    = phase_q;
    size_hi_d  = size_hi_q;
    remain_d   = remain_q;
    top_d      = top_q;
    fu_hdr_d   = 1'b0;
    cmd_o.kind = KIND_NONE;
    cmd_o.data = in_byte_i;

    if (first_byte_i) begin
      zeros_d   = 2'd0;
      phase_d   = PHASE_SIZE_HI;
      size_hi_d = 8'h00;
      remain_d  = 16'h0000;
      top_d     = 3'd0;
      fu_hdr_d  = 1'b1;
      if (in_byte_i == 8'h00) begin
        mode_d  = MODE_ZEROS;
        zeros_d = 2'd1;
      end else if (type_field inside {[5'd1:5'd23]}) begin
        cmd_o.kind = KIND_PREFIX_BYTE;
        mode_d     = MODE_PASS;
      end else if (type_field == 5'd24) begin
        mode_d = MODE_STAP;
      end else if (type_field == 5'd28) begin
        mode_d = MODE_FU;
        top_d  = in_byte_i[7:5];
      end else begin
        mode_d = MODE_DROP;
      end
    end else begin
      case (mode_q)
        MODE_PASS: cmd_o.kind = KIND_ONE;
        MODE_ZEROS: begin
          if (zeros_q == 2'd1) begin
            if (in_byte_i == 8'h00) zeros_d = 2'd2;
            else mode_d = MODE_DROP;
          end else if (zeros_q == 2'd2) begin
            if (in_byte_i == 8'h01) begin
              cmd_o.kind = KIND_PREFIX;
              mode_d     = MODE_PASS;
            end else if (in_byte_i == 8'h00) begin
              zeros_d = 2'd3;
            end else begin
              mode_d = MODE_DROP;
            end
          end else begin
            if (in_byte_i == 8'h01) begin
              cmd_o.kind = KIND_LONG;
              mode_d     = MODE_PASS;
            end else begin
              mode_d = MODE_DROP;
            end
          end
        end
        MODE_STAP: begin
          if (phase_q == PHASE_SIZE_HI) begin
            size_hi_d = in_byte_i;
            phase_d   = PHASE_SIZE_LO;
          end else if (phase_q == PHASE_SIZE_LO) begin
            remain_d = size_full;
            if (size_full == 16'h0000) begin
              phase_d = PHASE_SIZE_HI;
            end else begin
              cmd_o.kind = KIND_PREFIX;
              phase_d    = PHASE_DATA;
            end
          end else begin
            cmd_o.kind = KIND_ONE;
            remain_d   = remain_dec;
            if (remain_dec == 16'h0000) phase_d = PHASE_SIZE_HI;
          end
        end
        MODE_FU: begin
          if (fu_hdr_q) begin
            if (in_byte_i[7]) begin
              cmd_o.kind = KIND_PREFIX_BYTE;
              cmd_o.data = ({top_q, 5'd0} & TopMask) | (in_byte_i & TypeMask);
            end
          end else begin
            cmd_o.kind = KIND_ONE;
          end
        end
        default: ;
      endcase
    end

    // The packet end returns all state to idle once the word is handled.
    if (last_byte_i) begin
      mode_d    = MODE_IDLE;
      zeros_d   = 2'd0;
      phase_d   = PHASE_SIZE_HI;
      size_hi_d = 8'h00;
      remain_d  = 16'h0000;
      top_d     = 3'd0;
      fu_hdr_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      zeros_q   <= 2'd0;
      phase_q   <= PHASE_SIZE_HI;
      size_hi_q <= 8'h00;
      remain_q  <= 16'h0000;
      top_q     <= 3'd0;
      fu_hdr_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      zeros_q   <= zeros_d;
      phase_q   <= phase_d;
      size_hi_q <= size_hi_d;
      remain_q  <= remain_d;
      top_q     <= top_d;
      fu_hdr_q  <= fu_hdr_d;
    end
  end

endmodule

@@ rtl/h264dp_queue.sv @@
// Small command queue between the front end and the output sequencer.
module h264dp_queue #(
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  h264dp_pkg::cmd_t push_cmd_i,
  input  logic             pop_i,
  output h264dp_pkg::cmd_t head_o,
  output logic             empty_o,
  output logic             full_o
);
  import h264dp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntFull);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrOne;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrOne;
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntOne;
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntOne;
    end
  end

endmodule

@@ rtl/h264dp_back.sv @@
// Output sequencer: expands queued commands into stream words in an output register.
module h264dp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  h264dp_pkg::cmd_t head_i,
  input  logic             head_valid_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             unit_start_o,
  output logic             run_last_o
);
  import h264dp_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  logic       start_q, last_q;
  logic [1:0] idx_q;
  logic       load, at_end;

  assign load   = !valid_q || !out_stall_i;
  assign at_end = (idx_q == last_index(head_i.kind));
  assign pop_o  = load && head_valid_i && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= head_valid_i;
      if (head_valid_i) idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      byte_q  <= word_byte(head_i.kind, idx_q, head_i.data);
      start_q <= (idx_q == 2'd0) && (head_i.kind != KIND_ONE);
      last_q  <= at_end;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign unit_start_o = start_q;
  assign run_last_o   = last_q;

endmodule

@@ rtl/h264_rtp_depacketizer_unit.sv @@
// H.264 RTP depacketizer: payload words in, Annex-B stream words out.
// Each accepted word is classified into a command, queued, then expanded by the sequencer.
// Throughput: one input word per cycle while the command queue has room; one output
// word per cycle from the sequencer while the output is not stalled, up to four per
// input word at unit starts.
// The queue depth sets how long a burst of start codes can be absorbed.
// Reset (rst_ni low, asynchronous) empties the queue and returns the packet state to idle.
module h264_rtp_depacketizer_unit #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       unit_start_o,
  output logic       run_last_o
);
  import h264dp_pkg::*;

  cmd_t cmd, head;
  logic accept, q_push, q_pop, q_empty, q_full;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;
  assign q_push     = accept && (cmd.kind != KIND_NONE);

  h264dp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .cmd_o        (cmd)
  );

  h264dp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (cmd),
    .pop_i      (q_pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  h264dp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .unit_start_o (unit_start_o),
    .run_last_o   (run_last_o)
  );

  // A start code always opens with a zero word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unit_start_o) |-> (out_byte_o == 8'h00))
    else $error("start code word is not zero");

  // Inside one expansion the next word can never open a new start code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !run_last_o) |=> (out_valid_o && !unit_start_o))
    else $error("expansion interrupted by a new start code");

  // The front end never writes a command into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

endmodule

@@ tb/h264_rtp_depacketizer_unit_tb.sv @@
// Self-checking testbench for the H.264 RTP depacketizer: payload words in, Annex-B words out.
`timescale 1ns / 100ps

module h264_rtp_depacketizer_unit_tb;
  import h264dp_pkg::*;

  typedef enum logic [2:0] {
    PkIdle,
    PkZeros,
    PkPass,
    PkStap,
    PkFu,
    PkDrop
  } packet_mode_e;

  typedef enum logic [1:0] {
    SzHigh,
    SzLow,
    SzData
  } size_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
  } stream_word_t;

  localparam logic [4:0] NalFirst    = 5'd1;
  localparam logic [4:0] NalLast     = 5'd23;
  localparam logic [4:0] NalStapA    = 5'd24;
  localparam logic [4:0] NalFuA      = 5'd28;
  localparam logic [7:0] FuStartMask = 8'h80;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [7:0] in_byte_i    = 8'h00;
  logic       first_byte_i = 1'b0;
  logic       last_byte_i  = 1'b0;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       unit_start_o;
  logic       run_last_o;

  h264_rtp_depacketizer_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .unit_start_o (unit_start_o),
    .run_last_o   (run_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state for the packet being depacketized.
  packet_mode_e mode;
  size_phase_e  size_phase;
  logic [15:0]  pos;
  logic [15:0]  unit_left;
  logic [7:0]   size_hi;
  logic [1:0]   zeros_seen;
  logic [2:0]   fu_top;

  stream_word_t annexb_q[$];
  stream_word_t run_q[$];
  stream_word_t got_word;
  logic [7:0]   pkt_q[$];

  int err_count      = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int payload_sent   = 0;

  function automatic void reset_packet_state();
    mode       = PkIdle;
    size_phase = SzHigh;
    pos        = 16'd0;
    unit_left  = 16'd0;
    size_hi    = 8'd0;
    zeros_seen = 2'd0;
    fu_top     = 3'd0;
  endfunction

  function automatic void emit(input logic [7:0] data, input logic start);
    stream_word_t w;
    w.data  = data;
    w.start = start;
    w.last  = 1'b0;
    run_q.push_back(w);
  endfunction

  function automatic void emit_start_code();
    emit(StartCode0, 1'b1);
    emit(StartCode1, 1'b0);
    emit(StartCode2, 1'b0);
  endfunction

  // Expands one accepted payload word into the Annex-B words it produces.
  function automatic void depacketize_word(input logic [7:0] b, input logic f, input logic l);
    logic [4:0]   nal;
    stream_word_t w;
    int           i;
    run_q.delete();
    nal = 5'(b & TypeMask);
    if (f) begin
      reset_packet_state();
      if (b == 8'h00) begin
        mode       = PkZeros;
        zeros_seen = 2'd1;
      end else if (nal >= NalFirst && nal <= NalLast) begin
        emit_start_code();
        emit(b, 1'b0);
        mode = PkPass;
      end else if (nal == NalStapA) begin
        mode = PkStap;
      end else if (nal == NalFuA) begin
        mode   = PkFu;
        fu_top = 3'((b & TopMask) >> 5);
      end else begin
        mode = PkDrop;
      end
    end else begin
      case (mode)
        PkPass: emit(b, 1'b0);
        PkZeros: begin
          if (zeros_seen == 2'd1) begin
            if (b == 8'h00) zeros_seen = 2'd2;
            else mode = PkDrop;
          end else if (zeros_seen == 2'd2) begin
            if (b == StartCode2) begin
              emit_start_code();
              mode = PkPass;
            end else if (b == 8'h00) begin
              zeros_seen = 2'd3;
            end else begin
              mode = PkDrop;
            end
          end else if (b == StartCode2) begin
            // The four-byte start code is passed as it came.
            emit(StartCode0, 1'b1);
            emit(StartCode0, 1'b0);
            emit(StartCode1, 1'b0);
            emit(StartCode2, 1'b0);
            mode = PkPass;
          end else begin
            mode = PkDrop;
          end
        end
        PkStap: begin
          case (size_phase)
            SzHigh: begin
              size_hi    = b;
              size_phase = SzLow;
            end
            SzLow: begin
              unit_left = {size_hi, b};
              if (unit_left == 16'd0) begin
                size_phase = SzHigh;
              end else begin
                emit_start_code();
                size_phase = SzData;
              end
            end
            default: begin
              emit(b, 1'b0);
              unit_left = unit_left - 16'd1;
              if (unit_left == 16'd0) size_phase = SzHigh;
            end
          endcase
        end
        PkFu: begin
          // The FU header rebuilds the NAL header only on a start fragment.
          if (pos == 16'd1) begin
            if ((b & FuStartMask) != 8'h00) begin
              emit_start_code();
              emit({fu_top, nal}, 1'b0);
            end
          end else begin
            emit(b, 1'b0);
          end
        end
        default: ;
      endcase
    end
    if (pos != 16'hffff) pos = pos + 16'd1;
    for (i = 0; i < run_q.size(); i++) begin
      w      = run_q[i];
      w.last = (i == run_q.size() - 1);
      annexb_q.push_back(w);
    end
    if (l) reset_packet_state();
  endfunction

  function automatic void report_mismatch(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
    err_count++;
    $display("%t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (annexb_q.size() == 0) begin
        err_count++;
        $display("%t: unexpected word, expected none, actual %h", $time, out_byte_o);
      end else begin
        got_word = annexb_q.pop_front();
        if (out_byte_o !== got_word.data) report_mismatch("out_byte", got_word.data, out_byte_o);
        if (unit_start_o !== got_word.start)
          report_mismatch("unit_start", {7'd0, got_word.start}, {7'd0, unit_start_o});
        if (run_last_o !== got_word.last)
          report_mismatch("run_last", {7'd0, got_word.last}, {7'd0, run_last_o});
      end
    end
  end

  // Valid stays high from one word to the next unless a gap is drawn.
  task automatic send_word(input logic [7:0] b, input logic f, input logic l);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_byte_i    <= b;
    first_byte_i <= f;
    last_byte_i  <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    depacketize_word(b, f, l);
  endtask

  task automatic send_packet(input bit close);
    int i;
    for (i = 0; i < pkt_q.size(); i++) begin
      send_word(pkt_q[i], i == 0, close && (i == pkt_q.size() - 1));
    end
    payload_sent += pkt_q.size();
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (annexb_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_start_code_passthrough();
    pkt_q = '{8'h00, 8'h00, 8'h01, 8'h65};
    send_packet(1'b1);
    pkt_q = '{8'h00, 8'h00, 8'h00, 8'h01};
    send_packet(1'b1);
  endtask

  task automatic test_single_nal();
    pkt_q = '{8'hf7, 8'hff};
    send_packet(1'b1);
    // A word outside any packet is ignored.
    send_word(8'h5a, 1'b0, 1'b0);
    // This packet never ends: the next first word abandons it.
    pkt_q = '{8'he1};
    send_packet(1'b0);
  endtask

  task automatic test_aggregation();
    // A zero size is skipped, then one unit, then a unit cut off by the packet end.
    pkt_q = '{8'h78, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h09, 8'hcc};
    send_packet(1'b1);
  endtask

  task automatic test_fragmentation();
    pkt_q = '{8'h7c, 8'h85, 8'h11};
    send_packet(1'b1);
    pkt_q = '{8'h3c};
    send_packet(1'b1);
  endtask

  task automatic test_drop_cases();
    pkt_q = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_packet(1'b1);
    pkt_q = '{8'h9f};
    send_packet(1'b1);
  endtask

  task automatic random_packet();
    int         pick;
    int         i;
    int         units;
    int         body;
    logic [2:0] top;
    logic [4:0] nal;
    logic [7:0] sz_lo;
    bit         close;
    pkt_q.delete();
    pick  = $urandom_range(99);
    top   = 3'($urandom_range(7));
    close = ($urandom_range(9) != 0);
    if (pick < 22) begin
      nal = 5'($urandom_range(NalLast, NalFirst));
      pkt_q.push_back({top, nal});
      repeat ($urandom_range(6)) pkt_q.push_back(8'($urandom_range(255)));
    end else if (pick < 34) begin
      pkt_q.push_back(8'h00);
      pkt_q.push_back(8'h00);
      if ($urandom_range(1)) pkt_q.push_back(8'h00);
      pkt_q.push_back(8'h01);
      repeat ($urandom_range(5)) pkt_q.push_back(8'($urandom_range(255)));
    end else if (pick < 56) begin
      pkt_q.push_back({top, NalStapA});
      units = $urandom_range(3, 1);
      for (i = 0; i < units; i++) begin
        if ($urandom_range(9) == 0) begin
          // Oversized unit, cut off at the packet end.
          pkt_q.push_back(8'($urandom_range(255, 1)));
          pkt_q.push_back(8'($urandom_range(255)));
          body = $urandom_range(3);
        end else begin
          sz_lo = 8'($urandom_range(4));
          pkt_q.push_back(8'h00);
          pkt_q.push_back(sz_lo);
          body = int'(sz_lo);
        end
        repeat (body) pkt_q.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(7) == 0) pkt_q.push_back(8'($urandom_range(255)));
    end else if (pick < 80) begin
      pkt_q.push_back({top, NalFuA});
      if ($urandom_range(3) != 0) begin
        pkt_q.push_back(8'($urandom_range(255)));
        repeat ($urandom_range(6)) pkt_q.push_back(8'($urandom_range(255)));
      end
    end else if (pick < 86) begin
      do nal = 5'($urandom_range(31));
      while ((nal >= NalFirst && nal <= NalStapA) || nal == NalFuA);
      pkt_q.push_back({top, nal});
      repeat ($urandom_range(3)) pkt_q.push_back(8'($urandom_range(255)));
    end else if (pick < 92) begin
      pkt_q.push_back(8'h00);
      repeat ($urandom_range(4, 1)) begin
        case ($urandom_range(2))
          0:       pkt_q.push_back(8'h00);
          1:       pkt_q.push_back(8'h01);
          default: pkt_q.push_back(8'($urandom_range(255)));
        endcase
      end
    end else if (pick < 96) begin
      repeat ($urandom_range(5, 1)) pkt_q.push_back(8'($urandom_range(255)));
    end
    if (pkt_q.size() == 0) begin
      // Stray words with no first flag; they do not count toward the item total.
      repeat ($urandom_range(2, 1))
        send_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
    end else begin
      send_packet(close);
    end
  endtask

  task automatic test_random(input int count);
    int stop_at;
    stop_at = payload_sent + count;
    while (payload_sent < stop_at) random_packet();
  endtask

  initial begin
    int drain_cycles;
    reset_packet_state();
    send_gap_pct   = 6;
    recv_stall_pct = 64;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_start_code_passthrough();
    test_single_nal();
    test_aggregation();
    test_fragmentation();
    test_drop_cases();
    hold_until_drained();

    test_random(150);
    hold_until_drained();
    send_gap_pct   = 64;
    recv_stall_pct = 6;
    test_random(150);
    hold_until_drained();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random(130);

    in_valid_i <= 1'b0;
    drain_cycles = 0;
    while (annexb_q.size() != 0 && drain_cycles < 100000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (annexb_q.size() != 0) begin
      err_count++;
      $display("%t: %0d words expected, actual none", $time, annexb_q.size());
    end
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("h264_rtp_depacketizer_unit_tb: done, clean");
    end else begin
      $display("h264_rtp_depacketizer_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("h264_rtp_depacketizer_unit_tb: done, errors");
    $finish;
  end

endmodule
